>>> rtl/ppm_pkg.sv
// ----------------------------------------------------------------------------
// ppm_pkg: shared types and constants for the phase-polynomial magnitude block
// Request structs, register indexes, fixed-point constants, log table function.
// ----------------------------------------------------------------------------
package ppm_pkg;

  localparam int DistWidthDefault = 44;
  localparam int LogDepthDefault  = 256;

  localparam int FracBits = 24;
  localparam logic [30:0] ScaleQ30  = 31'd1616142483;
  localparam logic [31:0] OffsetQ24 = 32'd1874842765;
  localparam logic signed [45:0] SumLimit = 46'sd17592186044416;
  localparam logic signed [23:0] MagMax = 24'sh7fffff;
  localparam logic signed [23:0] MagMin = -24'sh800000;

  // Register indexes
  localparam logic [2:0] RegAbsMag = 3'd0;
  localparam logic [2:0] RegCoef1  = 3'd1;
  localparam logic [2:0] RegCoef2  = 3'd2;
  localparam logic [2:0] RegCoef3  = 3'd3;
  localparam logic [2:0] RegCoef4  = 3'd4;

  typedef struct packed {
    logic [43:0] sun_distance;
    logic [43:0] observer_distance;
    logic [17:0] phase;
  } ppm_in_t;

  typedef struct packed {
    logic signed [23:0] magnitude;
    logic               out_of_range;
  } ppm_out_t;

  // log2(1 + i/depth) in Q0.24 by repeated squaring of a Q1.31 mantissa.
  // Evaluated only at elaboration to build constant tables.
  function automatic logic [24:0] log_frac(input int i, input int depth);
    logic [63:0] x;
    logic [24:0] y;
    if (i >= depth) begin
      log_frac = 25'd1 << FracBits;
    end else begin
      x = (64'd1 << 31) + ((64'(i) << 31) / 64'(depth));
      y = '0;
      for (int b = FracBits - 1; b >= 0; b--) begin
        x = (x * x) >> 31;
        if (x >= (64'd1 << 32)) begin
          x = x >> 1;
          y[b] = 1'b1;
        end
      end
      log_frac = y;
    end
  endfunction

endpackage

>>> rtl/ppm_log2.sv
// ----------------------------------------------------------------------------
// ppm_log2: pipelined log2 of a nonzero distance, Q8.24
// Stage A finds the leading one and normalizes; stage B reads the table and
// registers the delta; stage C multiplies the remainder and adds.
// ----------------------------------------------------------------------------
module ppm_log2 import ppm_pkg::*; #(
  parameter int DIST_WIDTH      = DistWidthDefault,
  parameter int LOG_TABLE_DEPTH = LogDepthDefault
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [DIST_WIDTH-1:0] distance,
  output logic [31:0]           log_q24
);
  localparam int IdxW = $clog2(LOG_TABLE_DEPTH);
  localparam int TblW = $clog2(LOG_TABLE_DEPTH + 1);
  localparam int PosW = $clog2(DIST_WIDTH);

  logic [24:0] tbl [LOG_TABLE_DEPTH+1];
  always_comb begin
    for (int i = 0; i <= LOG_TABLE_DEPTH; i++) tbl[i] = log_frac(i, LOG_TABLE_DEPTH);
  end

  // Leading one and normalized fraction (bits below the leading one)
  logic [PosW-1:0]       pos_c;
  logic [DIST_WIDTH-1:0] norm_c;
  always_comb begin
    pos_c = '0;
    for (int b = 0; b < DIST_WIDTH; b++) if (distance[b]) pos_c = PosW'(b);
    norm_c = distance << (PosW'(DIST_WIDTH - 1) - pos_c);
  end

  logic [PosW-1:0] pos_a;
  logic [31:0]     frac_a;
  always_ff @(posedge clk) begin
    if (en) begin
      pos_a <= pos_c;
      // top 32 bits below the leading one, zero padded when the word is short
      frac_a <= 32'({norm_c[DIST_WIDTH-2:0], 32'd0} >> (DIST_WIDTH - 1));
    end
  end

  // Table lookup: scale the fraction by the depth; the upper word is the
  // segment index, the lower word the position inside the segment
  logic [63:0]       seg_a;
  logic [IdxW-1:0]   idx_a;
  logic [31:0]       rem_a;
  assign seg_a = 64'(frac_a) * 64'(LOG_TABLE_DEPTH);
  assign idx_a = IdxW'(seg_a[63:32]);
  assign rem_a = seg_a[31:0];

  logic [PosW-1:0] pos_b;
  logic [24:0]     lo_b;
  logic [24:0]     dlt_b;
  logic [31:0]     rem_b;
  always_ff @(posedge clk) begin
    if (en) begin
      pos_b <= pos_a;
      lo_b  <= tbl[TblW'(idx_a)];
      dlt_b <= tbl[TblW'(idx_a) + TblW'(1)] - tbl[TblW'(idx_a)];
      rem_b <= rem_a;
    end
  end

  // Interpolate and add the integer part
  logic [56:0] prod_b;
  assign prod_b = 57'(dlt_b) * 57'(rem_b);

  always_ff @(posedge clk) begin
    if (en) begin
      log_q24 <= (32'(pos_b) << FracBits) + 32'(lo_b) + 32'(prod_b >> 32);
    end
  end

endmodule

>>> rtl/polynomial_phase_magnitude_top.sv
// ----------------------------------------------------------------------------
// polynomial_phase_magnitude_top: apparent magnitude from distances and phase
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall carries sun and observer distances (meters)
// and the phase angle (Q2.16 rad); output channel out_valid/out_stall carries
// the Q8.16 magnitude and an out_of_range flag. A request is taken on an edge
// with valid high and stall low.
// One request is accepted every cycle unless a stalled result holds the
// pipeline. Three log2 stages run beside the first three Horner
// multiplies, the scale multiply shares a stage with the last Horner step,
// one stage sums, rounds and saturates, and three output registers follow.
// A stalled result holds the whole pipeline and raises in_stall; no
// request is lost or repeated.
// Reset clears all valid bits and the registers (absolute magnitude and the
// four phase coefficients) to zero. Registers sit on the APB port at byte
// addresses 8*i, 64-bit data; write only while idle.
// ----------------------------------------------------------------------------
module polynomial_phase_magnitude_top import ppm_pkg::*; #(
  parameter int LOG_TABLE_DEPTH = LogDepthDefault,
  parameter int DIST_WIDTH      = DistWidthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  ppm_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output ppm_out_t    out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  localparam int Stages = 8;

  // Configuration registers
  logic signed [23:0] absolute_magnitude;
  logic signed [39:0] coef [4];
  logic [2:0] reg_idx;
  assign reg_idx = paddr[5:3];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      absolute_magnitude <= '0;
      for (int i = 0; i < 4; i++) coef[i] <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        RegAbsMag: absolute_magnitude <= pwdata[23:0];
        RegCoef1:  coef[0] <= pwdata[39:0];
        RegCoef2:  coef[1] <= pwdata[39:0];
        RegCoef3:  coef[2] <= pwdata[39:0];
        RegCoef4:  coef[3] <= pwdata[39:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegAbsMag: prdata = 64'(absolute_magnitude);
      RegCoef1:  prdata = 64'(coef[0]);
      RegCoef2:  prdata = 64'(coef[1]);
      RegCoef3:  prdata = 64'(coef[2]);
      RegCoef4:  prdata = 64'(coef[3]);
      default:   prdata = '0;
    endcase
  end

  // Pipeline advances whenever the output is free
  logic en;
  logic [Stages-1:0] vld;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[Stages-2:0], in_valid};
  end
  assign out_valid = vld[Stages-1];

  logic [DIST_WIDTH-1:0] d1, d2;
  assign d1 = DIST_WIDTH'(64'(in_data.sun_distance));
  assign d2 = DIST_WIDTH'(64'(in_data.observer_distance));

  logic [31:0] l1, l2;
  ppm_log2 #(.DIST_WIDTH(DIST_WIDTH), .LOG_TABLE_DEPTH(LOG_TABLE_DEPTH)) u_log1 (
    .clk(clk), .en(en), .distance(d1), .log_q24(l1));
  ppm_log2 #(.DIST_WIDTH(DIST_WIDTH), .LOG_TABLE_DEPTH(LOG_TABLE_DEPTH)) u_log2 (
    .clk(clk), .en(en), .distance(d2), .log_q24(l2));

  // Side data carried along the pipeline
  logic               zero_p [4];
  logic [17:0]        phi_p  [3];
  logic signed [46:0] s_p    [4];
  logic signed [33:0] lt_p;

  // Horner step: clamp s + c, multiply by phi, round to Q24
  function automatic logic signed [46:0] horner(input logic signed [46:0] s,
                                                input logic signed [39:0] c,
                                                input logic [17:0] phi);
    logic signed [47:0] t;
    logic signed [65:0] p;
    t = 48'(s) + 48'(c);
    if (t > 48'(SumLimit)) t = 48'(SumLimit);
    if (t < -48'(SumLimit)) t = -48'(SumLimit);
    p = 66'(t) * $signed({48'd0, phi}) + 66'sd32768;
    horner = 47'(p >>> 16);
  endfunction

  logic [62:0] scaled;
  assign scaled = 63'(l1 + l2) * 63'(ScaleQ30) + (63'd1 << 29);

  always_ff @(posedge clk) begin
    if (en) begin
      zero_p[0] <= (d1 == '0) || (d2 == '0);
      phi_p[0]  <= in_data.phase;
      s_p[0]    <= horner('0, coef[3], in_data.phase);
      for (int i = 1; i < 4; i++) zero_p[i] <= zero_p[i-1];
      for (int i = 1; i < 3; i++) phi_p[i] <= phi_p[i-1];
      s_p[1] <= horner(s_p[0], coef[2], phi_p[0]);
      s_p[2] <= horner(s_p[1], coef[1], phi_p[1]);
      s_p[3] <= horner(s_p[2], coef[0], phi_p[2]);
      // log2 results arrive after stage 2; scale in stage 3
      lt_p <= $signed(34'(scaled >> 30)) - $signed({2'b0, OffsetQ24});
    end
  end

  // Final sum, round to Q16 and saturate
  logic signed [47:0] total;
  logic signed [39:0] magw;
  assign total = 48'(absolute_magnitude) * 48'sd256 + 48'(lt_p) + 48'(s_p[3])
               + 48'sd128;
  assign magw = 40'(total >>> 8);

  ppm_out_t res;
  always_ff @(posedge clk) begin
    if (en) begin
      res.out_of_range <= zero_p[3] || magw > 40'(MagMax) || magw < 40'(MagMin);
      if (zero_p[3] || magw < 40'(MagMin)) res.magnitude <= MagMin;
      else if (magw > 40'(MagMax))         res.magnitude <= MagMax;
      else                                 res.magnitude <= 24'(magw);
    end
  end

  // Hold the result through the remaining stages
  ppm_out_t res_p [3];
  always_ff @(posedge clk) begin
    if (en) begin
      res_p[0] <= res;
      for (int i = 1; i < 3; i++) res_p[i] <= res_p[i-1];
    end
  end
  assign out_data = res_p[2];

  // Assertions
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed under stall");
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output");
  a_zero_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.magnitude != MagMin && out_data.magnitude != MagMax
    |-> !out_data.out_of_range)
    else $error("flag raised on in-range result");

endmodule
